[hdl/adaptive_preemphasis_filter_defines.svh]
// Assertion macros for the adaptive pre-emphasis filter.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef ADAPTIVE_PREEMPHASIS_FILTER_DEFINES_SVH
`define ADAPTIVE_PREEMPHASIS_FILTER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define APF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define APF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/ape_pkg.sv]
// Shared constants, opcodes and controller/datapath interface structs
// for the adaptive pre-emphasis filter. No dependencies.
package ape_pkg;

  localparam int COEF_SHIFT = 5;
  localparam int BLOCK_MAX  = 4096;

  localparam int SMPW  = 26;
  localparam int COEFW = 4;
  localparam int PRODW = 2 * SMPW;
  localparam int ESUMW = 62;
  localparam int CSUMW = 63;
  localparam int QW    = COEF_SHIFT + 1;
  localparam int CNTW  = $clog2(BLOCK_MAX + 1);
  localparam int STEPW = $clog2(COEF_SHIFT);
  localparam int DATAW = 32;

  localparam int COEF_MAX_RAW = (1 << (COEF_SHIFT - 1)) - 1;
  localparam int COEF_MAX_I   = (COEF_MAX_RAW > 15) ? 15 : COEF_MAX_RAW;
  localparam logic [COEFW-1:0] COEF_MAX = COEFW'(COEF_MAX_I);

  localparam logic [1:0] OP_ANALYSE = 2'd0;
  localparam logic [1:0] OP_PRE     = 2'd1;
  localparam logic [1:0] OP_DE      = 2'd2;
  localparam logic [1:0] OP_LOAD    = 2'd3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic latch;      // request taken: capture fields
    logic load_coef;  // coefficient load request
    logic first_take; // first sample of a block
    logic mul_ee;     // product <= last * last
    logic acc_e;      // energy += product, product <= last * x
    logic acc_c;      // cross += product, advance pair
    logic div_init;
    logic div_step;
    logic cout;       // emit coefficient, clear analysis state
    logic fmul;       // product <= prev * coef
    logic fout;       // emit filtered sample
  } ape_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       first;
    logic       blk_done;
    logic       out_free;
  } ape_stat_t;

endpackage

[hdl/ape_dp.sv]
// Datapath: shared 26x26 multiplier, correlation sums, restoring divider
// for the coefficient, filter state and output register. Uses ape_pkg.
module ape_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ape_pkg::ape_cmd_t           cmd,
  output ape_pkg::ape_stat_t          stat,
  input  logic [1:0]                  in_tuser,
  input  logic                        in_tlast,
  input  logic [ape_pkg::DATAW-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ape_pkg::DATAW-1:0]   out_tdata,
  output logic                        out_tuser
);
  import ape_pkg::*;

  logic                    first_r, first_nxt;
  logic signed [SMPW-1:0]  last_r, last_nxt;
  logic [ESUMW-1:0]        energy_r, energy_nxt;
  logic [CSUMW-1:0]        cross_r, cross_nxt;
  logic [CNTW-1:0]         count_r, count_nxt;
  logic signed [SMPW-1:0]  prev_r, prev_nxt;
  logic [COEFW-1:0]        coef_r, coef_nxt;

  logic [1:0]              op_r;
  logic signed [SMPW-1:0]  x_r;
  logic                    end_r;
  logic signed [PRODW-1:0] prod_r;
  logic [ESUMW-1:0]        rem_r;
  logic [QW-1:0]           quo_r;

  logic                    out_vld_r, out_vld_nxt;
  logic                    out_kind_r;
  logic [SMPW-1:0]         out_smp_r;
  logic [COEFW-1:0]        out_coef_r;

  logic signed [SMPW-1:0]  mul_a, mul_b;
  logic signed [PRODW-1:0] mul_p;
  logic signed [PRODW-1:0] fsh;
  logic [SMPW-1:0]         y;
  logic [CSUMW-1:0]        rem_sh;
  logic                    rem_ge;
  logic                    rnd_up;
  logic [QW-1:0]           q_rnd;
  logic [COEFW-1:0]        coef_est;

  // single multiplier, operands picked by the current command
  always_comb begin
    if (cmd.fmul) begin
      mul_a = prev_r;
      mul_b = $signed({{(SMPW-COEFW){1'b0}}, coef_r});
    end else if (cmd.acc_e) begin
      mul_a = last_r;
      mul_b = x_r;
    end else begin
      mul_a = last_r;
      mul_b = last_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  // floor shift; only the low sample bits matter after wrapping
  assign fsh = prod_r >>> COEF_SHIFT;
  assign y   = (op_r == OP_PRE) ? SMPW'(x_r - fsh[SMPW-1:0])
                                : SMPW'(x_r + fsh[SMPW-1:0]);

  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, energy_r};
  assign rnd_up = rem_sh >= {1'b0, energy_r};
  assign q_rnd  = quo_r + QW'(rnd_up);

  always_comb begin
    if (energy_r == '0 || cross_r[CSUMW-1])
      coef_est = '0;
    else if (cross_r >= {1'b0, energy_r})
      coef_est = COEF_MAX;
    else if (q_rnd > QW'(COEF_MAX_I))
      coef_est = COEF_MAX;
    else
      coef_est = COEFW'(q_rnd);
  end

  always_comb begin
    first_nxt  = first_r;
    last_nxt   = last_r;
    energy_nxt = energy_r;
    cross_nxt  = cross_r;
    count_nxt  = count_r;
    prev_nxt   = prev_r;
    coef_nxt   = coef_r;
    if (cmd.load_coef) begin
      coef_nxt = in_tdata[SMPW+COEFW-1:SMPW];
    end
    if (cmd.first_take) begin
      first_nxt = 1'b0;
      count_nxt = CNTW'(1);
      last_nxt  = x_r;
    end
    if (cmd.acc_e) begin
      energy_nxt = energy_r + {{(ESUMW-PRODW){1'b0}}, prod_r};
    end
    if (cmd.acc_c) begin
      cross_nxt = cross_r + {{(CSUMW-PRODW){prod_r[PRODW-1]}}, prod_r};
      count_nxt = count_r + CNTW'(1);
      last_nxt  = x_r;
    end
    if (cmd.cout) begin
      coef_nxt   = coef_est;
      first_nxt  = 1'b1;
      last_nxt   = '0;
      energy_nxt = '0;
      cross_nxt  = '0;
      count_nxt  = '0;
    end
    if (cmd.fout) begin
      prev_nxt = (op_r == OP_PRE) ? x_r : $signed(y);
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.fout || cmd.cout)
      out_vld_nxt = 1'b1;
    else if (out_tready)
      out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b1;
      last_r    <= '0;
      energy_r  <= '0;
      cross_r   <= '0;
      count_r   <= '0;
      prev_r    <= '0;
      coef_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      energy_r  <= energy_nxt;
      cross_r   <= cross_nxt;
      count_r   <= count_nxt;
      prev_r    <= prev_nxt;
      coef_r    <= coef_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_tuser;
      x_r   <= $signed(in_tdata[SMPW-1:0]);
      end_r <= in_tlast;
    end
    if (cmd.mul_ee || cmd.acc_e || cmd.fmul) begin
      prod_r <= mul_p;
    end
    if (cmd.div_init) begin
      rem_r <= cross_r[ESUMW-1:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? ESUMW'(rem_sh - {1'b0, energy_r}) : rem_sh[ESUMW-1:0];
      quo_r <= {quo_r[QW-2:0], rem_ge};
    end
    if (cmd.fout) begin
      out_kind_r <= KIND_SAMPLE;
      out_smp_r  <= y;
      out_coef_r <= '0;
    end else if (cmd.cout) begin
      out_kind_r <= KIND_COEF;
      out_smp_r  <= '0;
      out_coef_r <= coef_est;
    end
  end

  assign stat.in_op    = in_tuser;
  assign stat.first    = first_r;
  assign stat.blk_done = end_r || (count_r >= CNTW'(BLOCK_MAX));
  assign stat.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(DATAW-SMPW-COEFW){1'b0}}, out_coef_r, out_smp_r};

endmodule

[hdl/ape_ctrl.sv]
// Controller FSM: sequences analysis, division and filter steps and
// issues datapath commands. Uses ape_pkg command/status structs.
module ape_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ape_pkg::ape_stat_t stat,
  output ape_pkg::ape_cmd_t  cmd
);
  import ape_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AMUL = 4'd1;
  localparam logic [3:0] S_AACC = 4'd2;
  localparam logic [3:0] S_AADD = 4'd3;
  localparam logic [3:0] S_ACHK = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_COUT = 4'd6;
  localparam logic [3:0] S_FMUL = 4'd7;
  localparam logic [3:0] S_FOUT = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [STEPW-1:0] step_r, step_nxt;
  logic             take;

  // no request is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.latch = take;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (stat.in_op)
            OP_ANALYSE: state_nxt = S_AMUL;
            OP_LOAD:    cmd.load_coef = 1'b1;
            default:    state_nxt = S_FMUL;
          endcase
        end
      end
      S_AMUL: begin
        if (stat.first) begin
          cmd.first_take = 1'b1;
          state_nxt      = S_ACHK;
        end else begin
          cmd.mul_ee = 1'b1;
          state_nxt  = S_AACC;
        end
      end
      S_AACC: begin
        cmd.acc_e = 1'b1;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        cmd.acc_c = 1'b1;
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        if (stat.blk_done) begin
          cmd.div_init = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEPW'(1);
        if (step_r == STEPW'(COEF_SHIFT - 1))
          state_nxt = S_COUT;
      end
      S_COUT: begin
        if (stat.out_free) begin
          cmd.cout  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FMUL: begin
        cmd.fmul  = 1'b1;
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (stat.out_free) begin
          cmd.fout  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[hdl/adaptive_preemphasis_filter.sv]
// Adaptive first-order pre-/de-emphasis filter with per-block coefficient
// estimate. Input stream: in_tuser = opcode (analyse, pre-emphasize,
// de-emphasize, load coefficient), in_tlast = end of analysis block,
// in_tdata = sample and coefficient to load. Output stream: out_tuser = 0 for
// a filtered sample, 1 for an estimated coefficient.
// Per request: a coefficient load completes at its accept; pre/de-emphasis
// multiplies (one shared 26x26 multiplier), then adds; analyse captures a
// block's first sample, while a later one forms the energy product, adds it
// while forming the cross product, then adds that, since the energy and cross
// products share that multiplier. A block end adds COEF_SHIFT restoring division
// steps (one quotient bit per cycle) and an emit step. Results leave from a
// one-deep output register. A new request may be taken while a result waits
// there; if the receiver stalls, the next result holds in its final step until
// the slot frees. Reset (rst_n low, synchronous) clears the sums, the previous
// sample, the coefficient and the output valid; in_tready stays low during
// reset and rises with rst_n, so a request can be taken once it is released.
// Uses ape_pkg, ape_ctrl, ape_dp.
`include "adaptive_preemphasis_filter_defines.svh"

module adaptive_preemphasis_filter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ape_pkg::DATAW-1:0] in_tdata,  // sample[25:0], coef_value[29:26]
  input  logic [1:0]                in_tuser,  // opcode[1:0]
  input  logic                      in_tlast,  // block_end
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ape_pkg::DATAW-1:0] out_tdata, // out_sample[25:0], out_coef[29:26]
  output logic                      out_tuser  // result_kind
);
  import ape_pkg::*;

  ape_cmd_t   cmd;
  ape_stat_t  stat;
  logic [8:0] dp_steps;
  logic       coef_ok;

  ape_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ape_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign dp_steps = {cmd.first_take, cmd.mul_ee, cmd.acc_e, cmd.acc_c, cmd.div_init,
                     cmd.div_step, cmd.cout, cmd.fmul, cmd.fout};
  assign coef_ok  = (out_tdata[SMPW-1:0] == '0) &&
                    (out_tdata[SMPW+COEFW-1:SMPW] <= COEF_MAX);

  // at most one datapath step per cycle
  `APF_ASSERT_ALWAYS(a_one_step, $onehot0(dp_steps))
  // a coefficient result carries a zero sample and a clamped coefficient
  `APF_ASSERT_ALWAYS(a_coef_fmt, !(out_tvalid && out_tuser == KIND_COEF) || coef_ok)
  // any request other than a coefficient load keeps the block busy
  `APF_ASSERT_NEXT(a_busy, in_tvalid && in_tready && in_tuser != OP_LOAD, !in_tready)
  // a result is only issued into a free output slot
  `APF_ASSERT_ALWAYS(a_slot_free, !(cmd.fout || cmd.cout) || stat.out_free)

endmodule

[test/adaptive_preemphasis_filter_test.sv]
// Self-checking bench for adaptive_preemphasis_filter: random and directed
// requests on the input stream, results compared against a built-in predictor.
// Depends on ape_pkg and the adaptive_preemphasis_filter RTL.
module adaptive_preemphasis_filter_test;
  import ape_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int RANDOM_REQUESTS = 1150;
  localparam logic signed [SMPW-1:0] SMP_MAX = 26'sh1FFFFFF;
  localparam logic signed [SMPW-1:0] SMP_MIN = 26'sh2000000;

  typedef struct {
    bit                   kind;
    bit signed [SMPW-1:0] sample;
    bit [COEFW-1:0]       coef;
  } filter_result_t;

  class apf_tracker;
    filter_result_t       expected_results[$];
    int                   mismatches;
    bit                   est_first;
    bit signed [SMPW-1:0] est_last;
    bit [ESUMW-1:0]       energy_acc;
    bit [CSUMW-1:0]       cross_acc;
    int                   est_count;
    bit signed [SMPW-1:0] hist_sample;
    bit [COEFW-1:0]       coef_reg;

    function new();
      mismatches  = 0;
      est_first   = 1;
      est_last    = '0;
      energy_acc  = '0;
      cross_acc   = '0;
      est_count   = 0;
      hist_sample = '0;
      coef_reg    = '0;
    endfunction

    // round(2^COEF_SHIFT * cross / energy) by restoring division
    function bit [COEFW-1:0] coef_estimate();
      bit [63:0] e;
      bit [63:0] c;
      bit [63:0] rem;
      bit [63:0] quo;
      e = 64'(energy_acc);
      c = 64'(cross_acc);
      quo = 0;
      if (e == 0 || c[CSUMW-1]) return '0;
      if (c >= e) return COEF_MAX;
      rem = c;
      for (int i = 0; i < COEF_SHIFT; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= e) begin
          rem = rem - e;
          quo[0] = 1'b1;
        end
      end
      if ((rem << 1) >= e) quo++;
      return (quo > COEF_MAX) ? COEF_MAX : quo[COEFW-1:0];
    endfunction

    function void take_request(bit [1:0] op, bit signed [SMPW-1:0] x, bit blk_end,
                               bit [COEFW-1:0] cv);
      filter_result_t       res;
      longint               prod;
      bit signed [SMPW-1:0] y;
      case (op)
        OP_ANALYSE: begin
          if (est_first) begin
            est_first = 0;
            est_count = 1;
          end else begin
            energy_acc = energy_acc + ESUMW'(longint'(est_last) * longint'(est_last));
            cross_acc  = cross_acc + CSUMW'(longint'(est_last) * longint'(x));
            est_count++;
          end
          est_last = x;
          if (blk_end || est_count >= BLOCK_MAX) begin
            coef_reg   = coef_estimate();
            res.kind   = KIND_COEF;
            res.sample = '0;
            res.coef   = coef_reg;
            expected_results.push_back(res);
            est_first  = 1;
            est_last   = '0;
            energy_acc = '0;
            cross_acc  = '0;
            est_count  = 0;
          end
        end
        OP_LOAD: coef_reg = cv;
        default: begin
          prod = longint'(hist_sample) * longint'(coef_reg);
          prod = prod >>> COEF_SHIFT;
          if (op == OP_PRE) begin
            y = x - SMPW'(prod);
            hist_sample = x;
          end else begin
            y = x + SMPW'(prod);
            hist_sample = y;
          end
          res.kind   = KIND_SAMPLE;
          res.sample = y;
          res.coef   = '0;
          expected_results.push_back(res);
        end
      endcase
    endfunction

    function void match_result(logic kind, logic [SMPW-1:0] smp, logic [COEFW-1:0] cf);
      filter_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: kind %0d sample %0d coef %0d",
               kind, $signed(smp), cf);
        mismatches++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (kind !== exp_res.kind) begin
        $error("result_kind: expected %0d, got %0d", exp_res.kind, kind);
        mismatches++;
      end
      if (smp !== exp_res.sample) begin
        $error("out_sample: expected %0d, got %0d", exp_res.sample, $signed(smp));
        mismatches++;
      end
      if (cf !== exp_res.coef) begin
        $error("out_coef: expected %0d, got %0d", exp_res.coef, cf);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [DATAW-1:0] in_tdata = '0;
  logic [1:0]       in_tuser = OP_ANALYSE;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DATAW-1:0] out_tdata;
  logic             out_tuser;

  apf_tracker tracker = new();
  int         quiet_cycles = 0;
  int         sent = 0;
  bit         no_idle = 0;
  bit         hold_off_req = 0;

  adaptive_preemphasis_filter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // accepted requests and results, plus the stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.take_request(in_tuser, in_tdata[SMPW-1:0], in_tlast,
                             in_tdata[SMPW+COEFW-1:SMPW]);
      if (out_tvalid && out_tready)
        tracker.match_result(out_tuser, out_tdata[SMPW-1:0], out_tdata[SMPW+COEFW-1:SMPW]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result receiver
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // called and returns at a falling edge
  task automatic send_req(input logic [1:0] op, input logic signed [SMPW-1:0] smp,
                          input bit blk, input logic [COEFW-1:0] cv);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {{(DATAW-SMPW-COEFW){1'b0}}, cv, smp};
    in_tuser  = op;
    in_tlast  = blk;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic signed [SMPW-1:0] any_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SMPW'($urandom_range(0, 255)) - 26'sd128;
      default: return SMPW'($urandom);
    endcase
  endfunction

  // first-order autoregressive samples so the estimate spans the whole range
  task automatic send_analysis_block(input int len, input bit well_formed);
    int                      k;
    int                      spread;
    int                      i;
    longint                  v;
    bit                      blk;
    logic signed [SMPW-1:0]  cur;
    k = int'($urandom_range(0, 32)) - 16;
    spread = 1 << $urandom_range(2, 22);
    cur = any_sample();
    for (i = 1; i <= len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_req($urandom_range(0, 1) ? OP_PRE : OP_DE, any_sample(),
                 1'($urandom_range(0, 1)), COEFW'($urandom));
      blk = (i == len) || (!well_formed && $urandom_range(0, 9) == 0);
      send_req(OP_ANALYSE, cur, blk, COEFW'($urandom));
      v = ((longint'(cur) * k) >>> 4) + longint'($urandom_range(0, 2 * spread)) - spread;
      if (v > SMP_MAX) v = SMP_MAX;
      if (v < SMP_MIN) v = SMP_MIN;
      cur = SMPW'(v);
    end
  endtask

  task automatic send_filter_run(input int len);
    int i;
    if ($urandom_range(0, 2) == 0) send_req(OP_LOAD, any_sample(), 1'($urandom_range(0, 1)),
                                            COEFW'($urandom));
    for (i = 0; i < len; i++)
      send_req($urandom_range(0, 1) ? OP_PRE : OP_DE, any_sample(), 1'($urandom_range(0, 1)),
               COEFW'($urandom));
  endtask

  initial begin
    int round;
    int sel;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: filter extremes and wrap, estimate special cases
    send_req(OP_PRE, 26'sd0, 1'b0, 4'h0);
    send_req(OP_ANALYSE, SMP_MAX, 1'b1, 4'h0);      // one-sample block
    send_req(OP_LOAD, 26'sd0, 1'b0, 4'hF);
    send_req(OP_PRE, SMP_MAX, 1'b1, 4'h0);          // tlast ignored on filter ops
    send_req(OP_PRE, SMP_MIN, 1'b0, 4'hF);          // wraps
    send_req(OP_DE, SMP_MAX, 1'b0, 4'h0);
    send_req(OP_DE, SMP_MAX, 1'b0, 4'h0);           // wraps
    send_req(OP_DE, SMP_MIN, 1'b0, 4'h0);
    send_req(OP_ANALYSE, 26'sd0, 1'b0, 4'h0);       // zero energy
    send_req(OP_ANALYSE, 26'sd0, 1'b1, 4'h0);
    send_req(OP_ANALYSE, 26'sd1000, 1'b0, 4'h0);    // negative cross
    send_req(OP_ANALYSE, -26'sd1000, 1'b1, 4'h0);
    send_req(OP_ANALYSE, 26'sd1000, 1'b0, 4'h0);    // cross above energy: clamp
    send_req(OP_ANALYSE, 26'sd1000, 1'b0, 4'h0);
    send_req(OP_ANALYSE, 26'sd2000, 1'b1, 4'h0);
    send_req(OP_ANALYSE, 26'sd64, 1'b0, 4'h0);      // exact half rounds up
    send_req(OP_ANALYSE, 26'sd1, 1'b1, 4'h0);
    send_req(OP_ANALYSE, SMP_MIN, 1'b0, 4'h0);
    send_req(OP_ANALYSE, SMP_MIN, 1'b1, 4'h0);
    send_req(OP_ANALYSE, SMP_MIN, 1'b0, 4'h0);
    send_req(OP_ANALYSE, SMP_MAX, 1'b1, 4'h0);
    send_req(OP_LOAD, -26'sd1, 1'b1, 4'hA);
    send_req(OP_PRE, -26'sd1, 1'b0, 4'h5);
    send_req(OP_LOAD, 26'sd0, 1'b0, 4'h5);
    send_req(OP_DE, -26'sd1, 1'b0, 4'hA);

    round = 0;
    while (sent < RANDOM_REQUESTS) begin
      round++;
      if (round == 20) hold_off_req = 1;
      if (round == 45) begin
        in_tvalid = 1'b0;
        while (tracker.expected_results.size() != 0) @(negedge clk);
      end
      if (round % 6 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 5) send_analysis_block($urandom_range(1, 12), 1'b1);
      else if (sel < 6) send_analysis_block($urandom_range(2, 16), 1'b0);
      else if (sel < 9) send_filter_run($urandom_range(1, 8));
      else send_req(2'($urandom), SMPW'($urandom), 1'($urandom_range(0, 1)), COEFW'($urandom));
    end
    in_tvalid = 1'b0;

    while (tracker.expected_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
